>>> rtl/uet_pkg.sv
`default_nettype none

package uet_pkg;

   localparam int NODE_BITS     = 16;
   localparam int NCOUNT_BITS   = 17;
   localparam int CMD_BITS      = 2;
   localparam int STATUS_BITS   = 4;
   localparam int DEGREE_BITS   = 7;
   localparam int DEF_MAX_EDGES = 64;

   localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_NEIGH = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TOP   = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_ADDED   = 4'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE   = 4'd1;
   localparam logic [STATUS_BITS-1:0] ST_SELF    = 4'd2;
   localparam logic [STATUS_BITS-1:0] ST_DUP     = 4'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 4'd4;
   localparam logic [STATUS_BITS-1:0] ST_NEIGH   = 4'd5;
   localparam logic [STATUS_BITS-1:0] ST_NONE    = 4'd6;
   localparam logic [STATUS_BITS-1:0] ST_TOP     = 4'd7;
   localparam logic [STATUS_BITS-1:0] ST_CLEARED = 4'd8;

   typedef struct packed {
      logic [NODE_BITS-1:0] lo;
      logic [NODE_BITS-1:0] hi;
   } pair_type;

   typedef struct packed {
      logic pair_hit;
      logic lo_hit;
      logic hi_hit;
   } match_type;

   typedef struct packed {
      logic                   valid;
      logic [STATUS_BITS-1:0] status;
      logic [NODE_BITS-1:0]   node_value;
      logic [DEGREE_BITS-1:0] degree;
      logic                   last;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/undirected_edge_table.sv
// undirected edge table
// keeps up to MAX_EDGES undirected links as (lower, higher) node pairs in
// insertion order. a request (req_cmd, req_node_a, req_node_b) is taken at
// a clock edge with start high and busy low; busy then stays high until the
// last result has been produced. results appear on the rsp_ ports for one
// cycle each, flagged by rsp_valid, with rsp_last on the final one. the
// receiver cannot hold them off.
// csr_data writes node_count through csr_valid/csr_ready; csr_ready is
// always high and writes belong in idle periods.
// each request works through one memory read port and one compare unit,
// one stored link per cycle: add and neighbours scan all stored links
// (neighbour results trickle out during the scan), clear scans nothing,
// and top node rescans the whole table for each endpoint inside the node
// range to count its degree.
// the final result is registered and shows in the cycle busy falls, when
// the next request can already be taken.
// reset empties the table and sets node_count to zero; link storage itself
// is not cleared and only entries below the fill count are ever read.
`default_nettype none

module undirected_edge_table import uet_pkg::*; #(
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [CMD_BITS-1:0]      req_cmd,
   input  wire logic [NODE_BITS-1:0]     req_node_a,
   input  wire logic [NODE_BITS-1:0]     req_node_b,
   output logic                          rsp_valid,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic [NODE_BITS-1:0]          rsp_node_value,
   output logic [DEGREE_BITS-1:0]        rsp_degree,
   output logic                          rsp_last,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [NCOUNT_BITS-1:0]   csr_data
);

   localparam int AddrBits = $clog2(MAX_EDGES);

   logic [NCOUNT_BITS-1:0] node_count_ff;
   logic [NCOUNT_BITS-1:0] node_count_in;

   logic                rd_en;
   logic [AddrBits-1:0] rd_addr;
   pair_type            rd_data;
   logic                wr_en;
   logic [AddrBits-1:0] wr_addr;
   pair_type            wr_data;
   logic [NODE_BITS-1:0] key_lo;
   logic [NODE_BITS-1:0] key_hi;
   match_type           hit;
   rsp_type             rsp;

   assign csr_ready     = 1'b1;
   assign node_count_in = (csr_valid && csr_ready) ? csr_data : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   uet_edge_mem #(
      .DEPTH     (MAX_EDGES),
      .ADDR_BITS (AddrBits)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   uet_match u_match (
      .stored (rd_data),
      .key_lo (key_lo),
      .key_hi (key_hi),
      .hit    (hit)
   );

   uet_engine #(
      .MAX_EDGES (MAX_EDGES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (req_cmd),
      .node_a     (req_node_a),
      .node_b     (req_node_b),
      .node_count (node_count_ff),
      .busy       (busy),
      .rsp        (rsp),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .key_lo     (key_lo),
      .key_hi     (key_hi),
      .hit        (hit)
   );

   assign rsp_valid      = rsp.valid;
   assign rsp_status     = rsp.status;
   assign rsp_node_value = rsp.node_value;
   assign rsp_degree     = rsp.degree;
   assign rsp_last       = rsp.last;

endmodule

`default_nettype wire

>>> rtl/uet_edge_mem.sv
`default_nettype none

module uet_edge_mem import uet_pkg::*; #(
   parameter int DEPTH     = DEF_MAX_EDGES,
   parameter int ADDR_BITS = $clog2(DEF_MAX_EDGES)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire pair_type             wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output pair_type                  rd_data
);

   pair_type store_ff [DEPTH];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/uet_match.sv
`default_nettype none

module uet_match import uet_pkg::*; (
   input  wire pair_type             stored,
   input  wire logic [NODE_BITS-1:0] key_lo,
   input  wire logic [NODE_BITS-1:0] key_hi,
   output match_type                 hit
);

   logic lo_eq;
   logic hi_eq;

   assign lo_eq = (stored.lo == key_lo);
   assign hi_eq = (stored.hi == key_hi);

   // for single-node lookups both keys carry the same node
   assign hit.pair_hit = lo_eq && hi_eq;
   assign hit.lo_hit   = lo_eq;
   assign hit.hi_hit   = hi_eq;

endmodule

`default_nettype wire

>>> rtl/uet_engine.sv
`default_nettype none

module uet_engine import uet_pkg::*; #(
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [CMD_BITS-1:0]               cmd,
   input  wire logic [NODE_BITS-1:0]              node_a,
   input  wire logic [NODE_BITS-1:0]              node_b,
   input  wire logic [NCOUNT_BITS-1:0]            node_count,
   output logic                                   busy,
   output rsp_type                                rsp,
   output logic                                   rd_en,
   output logic [$clog2(MAX_EDGES)-1:0]           rd_addr,
   input  wire pair_type                          rd_data,
   output logic                                   wr_en,
   output logic [$clog2(MAX_EDGES)-1:0]           wr_addr,
   output pair_type                               wr_data,
   output logic [NODE_BITS-1:0]                   key_lo,
   output logic [NODE_BITS-1:0]                   key_hi,
   input  wire match_type                         hit
);

   localparam int AddrBits = $clog2(MAX_EDGES);
   localparam int CntBits  = $clog2(MAX_EDGES + 1);
   localparam logic [CntBits-1:0] MaxCount = CntBits'(MAX_EDGES);
   localparam logic [CntBits-1:0] OneCount = CntBits'(1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISP     = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_TOP_RD   = 3'd3;
   localparam logic [2:0] S_TOP_CAND = 3'd4;

   logic [2:0]             state_ff,    state_in;
   logic [CMD_BITS-1:0]    cmd_ff,      cmd_in;
   logic [NODE_BITS-1:0]   a_ff,        a_in;
   logic [NODE_BITS-1:0]   b_ff,        b_in;
   logic [NODE_BITS-1:0]   key_lo_ff,   key_lo_in;
   logic [NODE_BITS-1:0]   key_hi_ff,   key_hi_in;
   logic [CntBits-1:0]     count_ff,    count_in;
   logic [CntBits-1:0]     j_ff,        j_in;
   logic                   rd_vld_ff,   rd_vld_in;
   logic                   found_ff,    found_in;
   logic                   hold_vld_ff, hold_vld_in;
   logic [NODE_BITS-1:0]   hold_val_ff, hold_val_in;
   logic [CntBits-1:0]     deg_ff,      deg_in;
   logic [NODE_BITS-1:0]   best_ff,     best_in;
   logic [CntBits-1:0]     best_deg_ff, best_deg_in;
   logic [CntBits-1:0]     i_ff,        i_in;
   logic                   side_ff,     side_in;
   rsp_type                rsp_ff,      rsp_in;

   function automatic rsp_type make_rsp(input logic [STATUS_BITS-1:0] st,
                                        input logic [NODE_BITS-1:0]   val,
                                        input logic [DEGREE_BITS-1:0] deg,
                                        input logic                   lst);
      rsp_type r;
      r.valid      = 1'b1;
      r.status     = st;
      r.node_value = val;
      r.degree     = deg;
      r.last       = lst;
      return r;
   endfunction

   always_comb begin
      logic                 adv;
      logic                 scan_more;
      logic                 scan_done;
      logic                 better;
      logic [NODE_BITS-1:0] cand;

      state_in    = state_ff;
      cmd_in      = cmd_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      key_lo_in   = key_lo_ff;
      key_hi_in   = key_hi_ff;
      count_in    = count_ff;
      j_in        = j_ff;
      rd_vld_in   = 1'b0;
      found_in    = found_ff;
      hold_vld_in = hold_vld_ff;
      hold_val_in = hold_val_ff;
      deg_in      = deg_ff;
      best_in     = best_ff;
      best_deg_in = best_deg_ff;
      i_in        = i_ff;
      side_in     = side_ff;
      rsp_in      = '0;
      rd_en       = 1'b0;
      rd_addr     = j_ff[AddrBits-1:0];
      wr_en       = 1'b0;
      wr_addr     = count_ff[AddrBits-1:0];
      wr_data     = '{lo: key_lo_ff, hi: key_hi_ff};
      adv         = 1'b0;
      scan_more   = (j_ff < count_ff);
      scan_done   = !scan_more && !rd_vld_ff;
      better      = (deg_ff > best_deg_ff) ||
                    ((deg_ff == best_deg_ff) && (deg_ff != '0) && (key_lo_ff < best_ff));
      cand        = side_ff ? rd_data.hi : rd_data.lo;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd;
               a_in     = node_a;
               b_in     = node_b;
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            unique case (cmd_ff)
               CMD_ADD: begin
                  if (({1'b0, a_ff} >= node_count) || ({1'b0, b_ff} >= node_count)) begin
                     rsp_in   = make_rsp(ST_RANGE, '0, '0, 1'b1);
                     state_in = S_IDLE;
                  end else if (a_ff == b_ff) begin
                     rsp_in   = make_rsp(ST_SELF, '0, '0, 1'b1);
                     state_in = S_IDLE;
                  end else begin
                     key_lo_in = (a_ff < b_ff) ? a_ff : b_ff;
                     key_hi_in = (a_ff < b_ff) ? b_ff : a_ff;
                     j_in      = '0;
                     found_in  = 1'b0;
                     state_in  = S_SCAN;
                  end
               end
               CMD_NEIGH: begin
                  key_lo_in   = a_ff;
                  key_hi_in   = a_ff;
                  j_in        = '0;
                  hold_vld_in = 1'b0;
                  state_in    = S_SCAN;
               end
               CMD_TOP: begin
                  i_in        = '0;
                  side_in     = 1'b0;
                  best_in     = '0;
                  best_deg_in = '0;
                  state_in    = S_TOP_RD;
               end
               CMD_CLEAR: begin
                  count_in = '0;
                  rsp_in   = make_rsp(ST_CLEARED, '0, '0, 1'b1);
                  state_in = S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_SCAN: begin
            // one read issued per cycle, the compare sees its data in the next cycle
            if (scan_more) begin
               rd_en     = 1'b1;
               rd_addr   = j_ff[AddrBits-1:0];
               j_in      = j_ff + OneCount;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               unique case (cmd_ff)
                  CMD_ADD: begin
                     if (hit.pair_hit) begin
                        found_in = 1'b1;
                     end
                  end
                  CMD_NEIGH: begin
                     // hold one match back so the final one can carry last
                     if (hit.lo_hit || hit.hi_hit) begin
                        if (hold_vld_ff) begin
                           rsp_in = make_rsp(ST_NEIGH, hold_val_ff, '0, 1'b0);
                        end
                        hold_val_in = hit.lo_hit ? rd_data.hi : rd_data.lo;
                        hold_vld_in = 1'b1;
                     end
                  end
                  CMD_TOP: begin
                     if (hit.lo_hit || hit.hi_hit) begin
                        deg_in = deg_ff + OneCount;
                     end
                  end
                  default: ;
               endcase
            end
            if (scan_done) begin
               unique case (cmd_ff)
                  CMD_ADD: begin
                     state_in = S_IDLE;
                     if (found_ff) begin
                        rsp_in = make_rsp(ST_DUP, '0, '0, 1'b1);
                     end else if (count_ff >= MaxCount) begin
                        rsp_in = make_rsp(ST_FULL, '0, '0, 1'b1);
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + OneCount;
                        rsp_in   = make_rsp(ST_ADDED, '0, '0, 1'b1);
                     end
                  end
                  CMD_NEIGH: begin
                     state_in = S_IDLE;
                     if (hold_vld_ff) begin
                        rsp_in = make_rsp(ST_NEIGH, hold_val_ff, '0, 1'b1);
                     end else begin
                        rsp_in = make_rsp(ST_NONE, '0, '0, 1'b1);
                     end
                  end
                  CMD_TOP: begin
                     if (better) begin
                        best_in     = key_lo_ff;
                        best_deg_in = deg_ff;
                     end
                     adv = 1'b1;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_TOP_RD: begin
            if (i_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = i_ff[AddrBits-1:0];
               state_in = S_TOP_CAND;
            end else begin
               rsp_in   = make_rsp(ST_TOP, best_ff, DEGREE_BITS'(best_deg_ff), 1'b1);
               state_in = S_IDLE;
            end
         end

         S_TOP_CAND: begin
            // endpoints outside the node range are no candidates
            if ({1'b0, cand} >= node_count) begin
               adv = 1'b1;
            end else begin
               key_lo_in = cand;
               key_hi_in = cand;
               j_in      = '0;
               deg_in    = '0;
               state_in  = S_SCAN;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (adv) begin
         state_in = S_TOP_RD;
         if (side_ff) begin
            side_in = 1'b0;
            i_in    = i_ff + OneCount;
         end else begin
            side_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
         rsp_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
         rsp_ff    <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      a_ff              <= a_in;
      b_ff              <= b_in;
      key_lo_ff         <= key_lo_in;
      key_hi_ff         <= key_hi_in;
      j_ff              <= j_in;
      found_ff          <= found_in;
      hold_vld_ff       <= hold_vld_in;
      hold_val_ff       <= hold_val_in;
      deg_ff            <= deg_in;
      best_ff           <= best_in;
      best_deg_ff       <= best_deg_in;
      i_ff              <= i_in;
      side_ff           <= side_in;
   end

   assign busy   = (state_ff != S_IDLE);
   assign rsp    = rsp_ff;
   assign key_lo = key_lo_ff;
   assign key_hi = key_hi_ff;

endmodule

`default_nettype wire

>>> rtl/uet_checker.sv
`default_nettype none

module uet_checker import uet_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire logic [STATUS_BITS-1:0] rsp_status,
   input wire logic [NODE_BITS-1:0]   rsp_node_value,
   input wire logic [DEGREE_BITS-1:0] rsp_degree,
   input wire logic                   rsp_last
);

   // an accepted request always keeps the block busy for its result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   // results only come out of a request in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in progress");

   // more results follow a non-final one, so the block is still at work
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result with block idle");

   // only neighbour and top results carry a value
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_NEIGH) && (rsp_status != ST_TOP)
         |-> (rsp_node_value == '0) && (rsp_degree == '0))
      else $error("payload not zero for this status");

   // these statuses always end the request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NONE || rsp_status == ST_TOP ||
                    rsp_status == ST_CLEARED) |-> rsp_last)
      else $error("single-result status without last");

endmodule

bind undirected_edge_table uet_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_node_value (rsp_node_value),
   .rsp_degree     (rsp_degree),
   .rsp_last       (rsp_last)
);

`default_nettype wire
